/* hw/rtl/pkl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkl_pkg
// Shared kernel codes and the control group of one update request.
// ----------------------------------------------------------------------------
package pkl_pkg;

   localparam logic [2:0] KIND_IDENT  = 3'd0;
   localparam logic [2:0] KIND_ARIKAN = 3'd1;
   localparam logic [2:0] KIND_K3A    = 3'd2;
   localparam logic [2:0] KIND_K3B    = 3'd3;
   localparam logic [2:0] KIND_K4     = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [1:0] phase;
      logic [2:0] bits;
   } pkl_ctl_type;

endpackage

/* hw/rtl/pkl_kernel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkl_kernel
// Min-sum kernel datapath: check-node and bit-conditioned sums for all
// kernels and phases, then selection and symmetric saturation.
// ----------------------------------------------------------------------------
module pkl_kernel #(
   parameter int LLR_WIDTH = 16
) (
   input  pkl_pkg::pkl_ctl_type          ctl,
   input  logic signed [LLR_WIDTH-1:0]   llr_0,
   input  logic signed [LLR_WIDTH-1:0]   llr_1,
   input  logic signed [LLR_WIDTH-1:0]   llr_2,
   input  logic signed [LLR_WIDTH-1:0]   llr_3,
   output logic signed [LLR_WIDTH-1:0]   llr_out,
   output logic                          bad_request
);
   import pkl_pkg::*;

   localparam int EW = LLR_WIDTH + 3;

   typedef logic signed [EW-1:0] ext_type;

   localparam ext_type SAT_MAX = {{(EW-LLR_WIDTH+1){1'b0}}, {(LLR_WIDTH-1){1'b1}}};
   localparam ext_type SAT_MIN = -SAT_MAX;

   function automatic ext_type abs_v(input ext_type a);
      return a[EW-1] ? -a : a;
   endfunction

   function automatic ext_type min_v(input ext_type a, input ext_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic ext_type flip(input logic b, input ext_type a);
      return b ? -a : a;
   endfunction

   function automatic ext_type chk2(input ext_type a, input ext_type b);
      ext_type m;
      m = min_v(abs_v(a), abs_v(b));
      return (a[EW-1] ^ b[EW-1]) ? -m : m;
   endfunction

   function automatic ext_type chk3(input ext_type a, input ext_type b, input ext_type c);
      ext_type m;
      m = min_v(min_v(abs_v(a), abs_v(b)), abs_v(c));
      return (a[EW-1] ^ b[EW-1] ^ c[EW-1]) ? -m : m;
   endfunction

   function automatic ext_type chk4(input ext_type a, input ext_type b,
                                    input ext_type c, input ext_type d);
      ext_type m;
      m = min_v(min_v(abs_v(a), abs_v(b)), min_v(abs_v(c), abs_v(d)));
      return (a[EW-1] ^ b[EW-1] ^ c[EW-1] ^ d[EW-1]) ? -m : m;
   endfunction

   ext_type l0, l1, l2, l3;
   logic    b0, b1, b2;
   ext_type c3, c4;
   ext_type k1p1, k2p1, k2p2, k3p1, k3p2, k4p1, k4p2, k4p3;
   ext_type r;
   logic    bad;

   assign l0 = EW'(llr_0);
   assign l1 = EW'(llr_1);
   assign l2 = EW'(llr_2);
   assign l3 = EW'(llr_3);
   assign b0 = ctl.bits[0];
   assign b1 = ctl.bits[1];
   assign b2 = ctl.bits[2];

   assign c3   = chk3(l0, l1, l2);
   assign c4   = chk4(l0, l1, l2, l3);
   assign k1p1 = flip(b0, l0) + l1;
   assign k2p1 = flip(b0, l0) + chk2(l1, l2);
   assign k2p2 = flip(b0, l1) + flip(b0 ^ b1, l2);
   assign k3p1 = chk2(flip(b0, l0), l2) + l1;
   assign k3p2 = flip(b0 ^ b1, l0) + l2;
   assign k4p1 = chk2(flip(b0, l0), l2) + chk2(l1, l3);
   assign k4p2 = chk2(flip(b0 ^ b1, l0) + l2, flip(b1, l1) + l3);
   assign k4p3 = flip(b0 ^ b1 ^ b2, l0) + flip(b1, l1) + flip(b2, l2) + l3;

   always_comb begin
      r   = '0;
      bad = 1'b0;
      case (ctl.kind)
         KIND_IDENT: begin
            if (ctl.phase == 2'd0) r = l0;
            else bad = 1'b1;
         end
         KIND_ARIKAN: begin
            case (ctl.phase)
               2'd0:    r = chk2(l0, l1);
               2'd1:    r = k1p1;
               default: bad = 1'b1;
            endcase
         end
         KIND_K3A: begin
            case (ctl.phase)
               2'd0:    r = c3;
               2'd1:    r = k2p1;
               2'd2:    r = k2p2;
               default: bad = 1'b1;
            endcase
         end
         KIND_K3B: begin
            case (ctl.phase)
               2'd0:    r = c3;
               2'd1:    r = k3p1;
               2'd2:    r = k3p2;
               default: bad = 1'b1;
            endcase
         end
         KIND_K4: begin
            case (ctl.phase)
               2'd0:    r = c4;
               2'd1:    r = k4p1;
               2'd2:    r = k4p2;
               default: r = k4p3;
            endcase
         end
         default: bad = 1'b1;
      endcase
   end

   always_comb begin
      if (r > SAT_MAX)      llr_out = SAT_MAX[LLR_WIDTH-1:0];
      else if (r < SAT_MIN) llr_out = SAT_MIN[LLR_WIDTH-1:0];
      else                  llr_out = r[LLR_WIDTH-1:0];
   end

   assign bad_request = bad;

endmodule

/* hw/rtl/polar_kernel_llr_update_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_kernel_llr_update_core
// Min-sum LLR update for one polar kernel (identity, 2x2, two 3x3, 4x4).
//
//   channel | direction | handshake           | beat
//   req     | in        | req_valid/req_stall | kind, phase, 4 llrs, 3 bits
//   rsp     | out       | rsp_valid/rsp_stall | llr_out, bad_request
//
// one beat per cycle sustained while rsp_stall is low; beats pass the input
// register, then the result register, with the kernel datapath between them
// a bubble in either register is filled while the result side stalls
// synchronous reset clears the valid flags only
// ----------------------------------------------------------------------------
module polar_kernel_llr_update_core #(
   parameter int LLR_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_kind,
   input  logic [1:0]                  req_phase,
   input  logic signed [LLR_WIDTH-1:0] req_llr_0,
   input  logic signed [LLR_WIDTH-1:0] req_llr_1,
   input  logic signed [LLR_WIDTH-1:0] req_llr_2,
   input  logic signed [LLR_WIDTH-1:0] req_llr_3,
   input  logic                        req_bit_0,
   input  logic                        req_bit_1,
   input  logic                        req_bit_2,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [LLR_WIDTH-1:0] rsp_llr_out,
   output logic                        rsp_bad_request
);
   import pkl_pkg::*;

   logic                        in_valid_ff;
   pkl_ctl_type                 in_ctl_ff;
   logic signed [LLR_WIDTH-1:0] in_llr_0_ff, in_llr_1_ff, in_llr_2_ff, in_llr_3_ff;
   logic                        rsp_valid_ff;
   logic signed [LLR_WIDTH-1:0] rsp_llr_ff;
   logic                        rsp_bad_ff;

   logic                        rsp_load;
   logic                        in_load;
   logic signed [LLR_WIDTH-1:0] k_llr;
   logic                        k_bad;

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign in_load   = !in_valid_ff || rsp_load;
   assign req_stall = !in_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_ctl_ff.kind  <= req_kind;
         in_ctl_ff.phase <= req_phase;
         in_ctl_ff.bits  <= {req_bit_2, req_bit_1, req_bit_0};
         in_llr_0_ff     <= req_llr_0;
         in_llr_1_ff     <= req_llr_1;
         in_llr_2_ff     <= req_llr_2;
         in_llr_3_ff     <= req_llr_3;
      end
   end

   pkl_kernel #(
      .LLR_WIDTH(LLR_WIDTH)
   ) u_kernel (
      .ctl        (in_ctl_ff),
      .llr_0      (in_llr_0_ff),
      .llr_1      (in_llr_1_ff),
      .llr_2      (in_llr_2_ff),
      .llr_3      (in_llr_3_ff),
      .llr_out    (k_llr),
      .bad_request(k_bad)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && in_valid_ff) begin
         rsp_llr_ff <= k_llr;
         rsp_bad_ff <= k_bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_llr_out     = rsp_llr_ff;
   assign rsp_bad_request = rsp_bad_ff;

`ifndef SYNTHESIS
   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_llr_ff == '0)
      else $error("bad request with nonzero llr");

   a_symmetric_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_llr_ff != {1'b1, {(LLR_WIDTH-1){1'b0}}})
      else $error("result outside symmetric range");

   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_load |=> rsp_valid_ff)
      else $error("beat lost between stages");

   a_held_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_load |=> in_valid_ff && $stable(in_ctl_ff))
      else $error("input register overwritten while blocked");
`endif

endmodule
